// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that stays active through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// Assertion that is switched off while the active-low reset is asserted.
`define ASSERT_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// ===== src/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

  localparam int ROM_NOTES            = 3;
  localparam int NOTES_PER_MELODY_DEF = 3;
  localparam int CMP_SHIFT            = 4;

  localparam logic [15:0] DIV_N0 = 16'd1515;
  localparam logic [15:0] DIV_N1 = 16'd1276;
  localparam logic [15:0] DIV_N2 = 16'd1012;
  localparam logic [15:0] DIV_N3 = 16'd851;

  localparam logic [15:0] DUR_SHORT_A = 16'd55;
  localparam logic [15:0] DUR_LONG_A  = 16'd80;
  localparam logic [15:0] DUR_SHORT_B = 16'd45;
  localparam logic [15:0] DUR_LONG_B  = 16'd70;
  localparam logic [15:0] DUR_LONG_C  = 16'd90;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_TONE   = 2'd1,
    MODE_MELODY = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] tone_divider;
    logic [15:0] duration_ms;
    logic [7:0]  melody_id;
  } in_item_t;

  typedef struct packed {
    logic        pwm_enable;
    logic [15:0] pwm_period;
    logic [11:0] pwm_compare;
    logic        tone_busy;
    logic        melody_playing;
  } out_item_t;

  // Melody ROM: m is the melody (0..2), n the note (0..2).
  function automatic logic [15:0] rom_div(input logic [1:0] m, input logic [1:0] n);
    logic [15:0] d;
    d = '0;
    unique case ({m, n})
      4'b00_00: d = DIV_N0;
      4'b00_01: d = DIV_N1;
      4'b00_10: d = DIV_N2;
      4'b01_00: d = DIV_N1;
      4'b01_01: d = DIV_N2;
      4'b01_10: d = DIV_N3;
      4'b10_00: d = DIV_N3;
      4'b10_01: d = DIV_N2;
      4'b10_10: d = DIV_N0;
      default:  d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] rom_dur(input logic [1:0] m, input logic [1:0] n);
    logic [15:0] d;
    d = '0;
    unique case ({m, n})
      4'b00_00: d = DUR_SHORT_A;
      4'b00_01: d = DUR_SHORT_A;
      4'b00_10: d = DUR_LONG_A;
      4'b01_00: d = DUR_SHORT_B;
      4'b01_01: d = DUR_SHORT_B;
      4'b01_10: d = DUR_LONG_B;
      4'b10_00: d = DUR_SHORT_A;
      4'b10_01: d = DUR_SHORT_A;
      4'b10_10: d = DUR_LONG_C;
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/bts_core.sv =====
`timescale 1ns / 1ps

module bts_core #(
  parameter int NOTES_PER_MELODY = bts_pkg::NOTES_PER_MELODY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bts_pkg::in_item_t   item,
  output bts_pkg::out_item_t  result
);

  // The melody ends after the shorter of the configured length and the ROM.
  localparam int NoteLimit = (NOTES_PER_MELODY < bts_pkg::ROM_NOTES) ?
                             NOTES_PER_MELODY : bts_pkg::ROM_NOTES;

  logic        busy_r, busy_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        mel_r, mel_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [1:0]  note_r, note_nxt;
  logic        pwm_r, pwm_nxt;
  logic [15:0] period_r, period_nxt;
  logic [11:0] compare_r, compare_nxt;

  logic [15:0] rem_dec;
  logic [2:0]  next_note;
  logic [1:0]  mel_idx;
  logic [15:0] note_div;

  always_comb begin
    busy_nxt    = busy_r;
    rem_nxt     = rem_r;
    mel_nxt     = mel_r;
    sel_nxt     = sel_r;
    note_nxt    = note_r;
    pwm_nxt     = pwm_r;
    period_nxt  = period_r;
    compare_nxt = compare_r;
    rem_dec     = rem_r - 16'd1;
    next_note   = {1'b0, note_r} + 3'd1;
    mel_idx     = sel_r - 2'd1;
    note_div    = bts_pkg::rom_div(mel_idx, next_note[1:0]);

    unique case (item.mode)
      bts_pkg::MODE_TICK: begin
        if (busy_r) begin
          rem_nxt = rem_dec;
          if (rem_dec == 16'd0) begin
            pwm_nxt  = 1'b0;
            busy_nxt = 1'b0;
            if (mel_r) begin
              if (next_note >= 3'(NoteLimit) || sel_r == 2'd0) begin
                mel_nxt  = 1'b0;
                note_nxt = 2'd0;
              end else begin
                note_nxt    = next_note[1:0];
                rem_nxt     = bts_pkg::rom_dur(mel_idx, next_note[1:0]);
                busy_nxt    = 1'b1;
                period_nxt  = note_div;
                compare_nxt = note_div[15:bts_pkg::CMP_SHIFT];
                pwm_nxt     = 1'b1;
              end
            end
          end
        end
      end
      bts_pkg::MODE_TONE: begin
        mel_nxt  = 1'b0;
        note_nxt = 2'd0;
        pwm_nxt  = 1'b0;
        if (item.duration_ms == 16'd0) begin
          busy_nxt = 1'b0;
        end else begin
          rem_nxt  = item.duration_ms;
          busy_nxt = 1'b1;
          if (item.tone_divider != 16'd0) begin
            period_nxt  = item.tone_divider;
            compare_nxt = item.tone_divider[15:bts_pkg::CMP_SHIFT];
            pwm_nxt     = 1'b1;
          end
        end
      end
      bts_pkg::MODE_MELODY: begin
        note_nxt = 2'd0;
        if (item.melody_id >= 8'd1 && item.melody_id <= 8'd3) begin
          mel_nxt     = 1'b1;
          sel_nxt     = item.melody_id[1:0];
          rem_nxt     = bts_pkg::rom_dur(item.melody_id[1:0] - 2'd1, 2'd0);
          busy_nxt    = 1'b1;
          period_nxt  = bts_pkg::rom_div(item.melody_id[1:0] - 2'd1, 2'd0);
          compare_nxt = period_nxt[15:bts_pkg::CMP_SHIFT];
          pwm_nxt     = 1'b1;
        end else begin
          mel_nxt  = 1'b0;
          pwm_nxt  = 1'b0;
          busy_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    result.pwm_enable     = pwm_nxt;
    result.pwm_period     = period_nxt;
    result.pwm_compare    = compare_nxt;
    result.tone_busy      = busy_nxt;
    result.melody_playing = mel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rem_r     <= '0;
      mel_r     <= 1'b0;
      sel_r     <= '0;
      note_r    <= '0;
      pwm_r     <= 1'b0;
      period_r  <= '0;
      compare_r <= '0;
    end else if (fire) begin
      busy_r    <= busy_nxt;
      rem_r     <= rem_nxt;
      mel_r     <= mel_nxt;
      sel_r     <= sel_nxt;
      note_r    <= note_nxt;
      pwm_r     <= pwm_nxt;
      period_r  <= period_nxt;
      compare_r <= compare_nxt;
    end
  end

endmodule

// ===== src/bts_skid.sv =====
`timescale 1ns / 1ps

module bts_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  bts_pkg::out_item_t  up_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bts_pkg::out_item_t  out_data
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  bts_pkg::out_item_t main_r;
  bts_pkg::out_item_t skid_r;
  logic               up_take;
  logic               main_free;

  assign up_stall  = skid_v_r;
  assign up_take   = up_valid && !skid_v_r;
  assign main_free = !main_v_r || !out_stall;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (main_free) begin
      main_v_nxt = skid_v_r || up_take;
      skid_v_nxt = 1'b0;
    end else if (up_take) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_v_r ? skid_r : up_data;
    end else if (up_take) begin
      skid_r <= up_data;
    end
  end

endmodule

// ===== src/buzzer_tone_melody_sequencer.sv =====
`timescale 1ns / 1ps

// Buzzer tone and melody sequencer.
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// item: a millisecond tick, a tone command or a melody command. Every input
// transaction produces exactly one output transaction (out_valid, out_stall,
// out_data) that shows the PWM enable, period, compare value, busy flag and
// melody flag as they stand after the item has been applied.
// An item lands in the input register on the edge that accepts it; when it
// moves on, the sequencer state and the result or skid register are updated
// together. Throughput is one item per cycle while the skid register is
// empty; the next-state logic is a single pass from input to result register.
// Behind the result register sits a one-entry skid register, so a stalled
// receiver does not stop the input side at once: in_stall rises only when both
// the result and skid registers are full and the input register holds an item.
// Stalled output transactions keep their payload until taken.
// Reset (rst_n low, synchronous) clears the sequencer state, the remaining
// time, the melody position and all valid flags; period and compare restart
// at zero.

module buzzer_tone_melody_sequencer #(
  parameter int NOTES_PER_MELODY = bts_pkg::NOTES_PER_MELODY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bts_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bts_pkg::out_item_t  out_data
);

  logic               in_v_r;
  bts_pkg::in_item_t  in_r;
  logic               res_stall;
  logic               fire;
  bts_pkg::out_item_t result;

  // The input register advances whenever its item moves into the result side.
  assign in_stall = in_v_r && res_stall;
  assign fire     = in_v_r && !res_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Sequencer state; it changes only when an item is handed to the result side.
  bts_core #(
    .NOTES_PER_MELODY(NOTES_PER_MELODY)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_r),
    .result (result)
  );

  // Result register with one skid entry.
  bts_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_v_r),
    .up_stall  (res_stall),
    .up_data   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/bts_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input bts_pkg::out_item_t out_data
);

  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)

  `ASSERT_RUN(a_stall_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  `ASSERT_RUN(a_pwm_needs_busy, clk, rst_n, out_valid && out_data.pwm_enable |-> out_data.tone_busy)

  `ASSERT_RUN(a_melody_needs_busy, clk, rst_n, out_valid && out_data.melody_playing |-> out_data.tone_busy)

  `ASSERT_RUN(a_cmp_period, clk, rst_n, out_valid |-> out_data.pwm_compare == out_data.pwm_period[15:4])

endmodule

bind buzzer_tone_melody_sequencer bts_checker u_bts_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // The block is built with its default melody length, and the predictor
  // uses the same value.
  localparam int MELODY_NOTES = bts_pkg::NOTES_PER_MELODY_DEF;

  // Mode 3 has no enum member. The block ignores it but still answers.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Budget for the whole run in clock cycles. The slowest correct run is far
  // below this: every wait between transactions on each side comes from
  // draw_gap, and there are two long holds on the result side.
  localparam int CYCLE_LIMIT = 200000;

  // Number of input transactions in the run.
  localparam int ITEM_TARGET = 500;

  // Number of cycles that the result side holds off during a long hold.
  localparam int LONG_HOLD = 150;

  // The scoreboard keeps its own copy of the sequencer state. Each accepted
  // input transaction is applied to that state, and the status that follows
  // is queued. Each output transaction is then checked against the oldest
  // queued status.
  class buzzer_status_board;
    bts_pkg::out_item_t expected_status[$];
    int unsigned        mismatches;

    logic        busy;
    logic [15:0] remain;
    logic        melody_on;
    logic [1:0]  melody_sel;
    logic [1:0]  note_pos;
    logic        pwm_on;
    logic [15:0] period;
    logic [11:0] compare;

    logic [15:0] note_div[3][3];
    logic [15:0] note_len[3][3];

    function new();
      note_div[0] = '{bts_pkg::DIV_N0, bts_pkg::DIV_N1, bts_pkg::DIV_N2};
      note_div[1] = '{bts_pkg::DIV_N1, bts_pkg::DIV_N2, bts_pkg::DIV_N3};
      note_div[2] = '{bts_pkg::DIV_N3, bts_pkg::DIV_N2, bts_pkg::DIV_N0};
      note_len[0] = '{bts_pkg::DUR_SHORT_A, bts_pkg::DUR_SHORT_A, bts_pkg::DUR_LONG_A};
      note_len[1] = '{bts_pkg::DUR_SHORT_B, bts_pkg::DUR_SHORT_B, bts_pkg::DUR_LONG_B};
      note_len[2] = '{bts_pkg::DUR_SHORT_A, bts_pkg::DUR_SHORT_A, bts_pkg::DUR_LONG_C};
      mismatches = 0;
      busy       = 1'b0;
      remain     = '0;
      melody_on  = 1'b0;
      melody_sel = '0;
      note_pos   = '0;
      pwm_on     = 1'b0;
      period     = '0;
      compare    = '0;
    endfunction

    function void report(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endfunction

    // A zero length stops the output. A zero divider is a silent rest that
    // still runs for its time, and period and compare keep their old values.
    function void program_tone(logic [15:0] div, logic [15:0] len);
      pwm_on = 1'b0;
      if (len == 16'd0) begin
        busy = 1'b0;
        return;
      end
      remain = len;
      busy   = 1'b1;
      if (div == 16'd0) begin
        return;
      end
      period  = div;
      compare = div[15:4];
      pwm_on  = 1'b1;
    endfunction

    function void start_note();
      logic [1:0] m;
      m = melody_sel - 2'd1;
      if (m > 2'd2 || note_pos >= bts_pkg::ROM_NOTES) begin
        melody_on = 1'b0;
        note_pos  = '0;
        program_tone(16'd0, 16'd0);
        return;
      end
      program_tone(note_div[m][note_pos], note_len[m][note_pos]);
    endfunction

    function void note_item(bts_pkg::in_item_t it);
      int unsigned        next_pos;
      bts_pkg::out_item_t status;
      unique case (it.mode)
        bts_pkg::MODE_TICK: begin
          // A tick only matters while a tone or rest is running.
          if (busy) begin
            remain = remain - 16'd1;
            if (remain == 16'd0) begin
              pwm_on = 1'b0;
              busy   = 1'b0;
              if (melody_on) begin
                next_pos = note_pos + 1;
                if (next_pos >= MELODY_NOTES || next_pos >= bts_pkg::ROM_NOTES) begin
                  melody_on = 1'b0;
                  note_pos  = '0;
                end else begin
                  note_pos = next_pos[1:0];
                  start_note();
                end
              end
            end
          end
        end
        bts_pkg::MODE_TONE: begin
          // A tone command cancels any melody in progress.
          melody_on = 1'b0;
          note_pos  = '0;
          program_tone(it.tone_divider, it.duration_ms);
        end
        bts_pkg::MODE_MELODY: begin
          note_pos = '0;
          if (it.melody_id >= 8'd1 && it.melody_id <= 8'd3) begin
            melody_on  = 1'b1;
            melody_sel = it.melody_id[1:0];
            start_note();
          end else begin
            // Any other melody number stops everything but leaves the
            // remaining time as it was.
            melody_on = 1'b0;
            program_tone(16'd0, 16'd0);
          end
        end
        default: begin
        end
      endcase
      status.pwm_enable     = pwm_on;
      status.pwm_period     = period;
      status.pwm_compare    = compare;
      status.tone_busy      = busy;
      status.melody_playing = melody_on;
      expected_status.push_back(status);
    endfunction

    function void check_status(bts_pkg::out_item_t got);
      bts_pkg::out_item_t want;
      if (expected_status.size() == 0) begin
        report("output transaction with no input transaction waiting");
        return;
      end
      want = expected_status.pop_front();
      if (got.pwm_enable !== want.pwm_enable) begin
        report($sformatf("pwm_enable %b, expected %b", got.pwm_enable, want.pwm_enable));
      end
      if (got.pwm_period !== want.pwm_period) begin
        report($sformatf("pwm_period %0d, expected %0d", got.pwm_period, want.pwm_period));
      end
      if (got.pwm_compare !== want.pwm_compare) begin
        report($sformatf("pwm_compare %0d, expected %0d", got.pwm_compare,
                         want.pwm_compare));
      end
      if (got.tone_busy !== want.tone_busy) begin
        report($sformatf("tone_busy %b, expected %b", got.tone_busy, want.tone_busy));
      end
      if (got.melody_playing !== want.melody_playing) begin
        report($sformatf("melody_playing %b, expected %b", got.melody_playing,
                         want.melody_playing));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  bts_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  bts_pkg::out_item_t out_data;

  buzzer_status_board sb;

  int unsigned cycle_count;
  int unsigned results_taken;
  int unsigned items_sent;
  int          send_burst;
  int          take_burst;

  buzzer_tone_melody_sequencer #(
    .NOTES_PER_MELODY(MELODY_NOTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  // Both channels are watched at the rising edge, where inputs driven at the
  // falling edge are stable and the block's outputs still hold the values
  // from before the edge. The input transaction is noted before the output
  // is checked, which is safe because the block never answers in the same
  // cycle.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_item(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      sb.check_status(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Waits between transactions are drawn at random. Now and then a run of
  // back-to-back transactions is mixed in, so that both dense and sparse
  // traffic occur.
  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Fields that a mode does not use are filled with random values, since
  // the block has to ignore them.
  function automatic bts_pkg::in_item_t rand_item(logic [1:0] mode);
    bts_pkg::in_item_t it;
    it.mode         = mode;
    it.tone_divider = 16'($urandom_range(0, 16'hFFFF));
    it.duration_ms  = 16'($urandom_range(0, 16'hFFFF));
    it.melody_id    = 8'($urandom_range(0, 8'hFF));
    return it;
  endfunction

  // Called at a falling edge and returns at a falling edge. The valid stays
  // high from one transaction to the next when there is no gap.
  task automatic send_item(bts_pkg::in_item_t it);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tone(logic [15:0] div, logic [15:0] len);
    bts_pkg::in_item_t it;
    it              = rand_item(bts_pkg::MODE_TONE);
    it.tone_divider = div;
    it.duration_ms  = len;
    send_item(it);
  endtask

  task automatic send_melody(logic [7:0] id);
    bts_pkg::in_item_t it;
    it           = rand_item(bts_pkg::MODE_MELODY);
    it.melody_id = id;
    send_item(it);
  endtask

  // Ticks stop early once the run has sent its share of transactions.
  task automatic send_ticks(int count);
    repeat (count) begin
      if (items_sent < ITEM_TARGET) begin
        send_item(rand_item(bts_pkg::MODE_TICK));
      end
    end
  endtask

  // The result side. Before each output transaction it draws a stall time.
  // Twice in the run it holds off for a long stretch, while the input side
  // keeps offering, so that the skid buffer fills and the block stalls its
  // input.
  initial begin
    int gap;
    int holds_done;
    int unsigned hold_point;
    out_stall  = 1'b0;
    take_burst = 0;
    holds_done = 0;
    hold_point = 120;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (holds_done < 2 && results_taken >= hold_point) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
        hold_point = hold_point + 250;
      end
      gap = draw_gap(take_burst);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int                pick;
    int unsigned       len;
    bts_pkg::in_item_t it;
    sb          = new();
    cycle_count = 0;
    results_taken = 0;
    items_sent  = 0;
    send_burst  = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. It covers a tick while idle, the unused mode, the
    // extremes of divider and duration, the silent rest, the stop by a zero
    // duration, the stop by a bad melody number, each melody, a melody that
    // restarts, and a tone command that cancels a melody.
    send_ticks(1);
    send_item(rand_item(MODE_UNUSED));
    send_tone(16'hFFFF, 16'd1);
    send_ticks(2);
    send_tone(16'd0, 16'd2);
    send_ticks(2);
    send_tone(16'd15, 16'hFFFF);
    send_ticks(1);
    send_tone(16'd16, 16'd0);
    send_tone(16'd1234, 16'd3);
    send_melody(8'd0);
    send_ticks(1);
    send_melody(8'd1);
    send_tone(16'd500, 16'd2);
    send_ticks(2);
    send_melody(8'd2);
    send_melody(8'd3);
    send_melody(8'd4);
    send_melody(8'd255);
    send_melody(8'd3);
    send_item(rand_item(MODE_UNUSED));
    send_ticks(1);

    // Random part. Most of it is well-formed: tones with short durations
    // that run out, and melodies played partly or fully through by ticks.
    // The rest breaks melodies off or sends fully random transactions.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(1, 8);
        send_tone(($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 16'hFFFF)),
                  16'(len));
        send_ticks($urandom_range(0, len + 2));
      end else if (pick < 55) begin
        send_melody(8'($urandom_range(1, 3)));
        send_ticks($urandom_range(0, 240));
      end else if (pick < 65) begin
        send_melody(8'($urandom_range(1, 3)));
        send_ticks($urandom_range(0, 120));
        if ($urandom_range(0, 1) == 0) begin
          send_tone(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16)));
        end else begin
          send_melody(8'($urandom_range(0, 8'hFF)));
        end
        send_ticks($urandom_range(0, 6));
      end else if (pick < 75) begin
        send_item(rand_item(bts_pkg::MODE_TONE));
        send_ticks($urandom_range(0, 5));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = rand_item(2'($urandom_range(0, 3)));
          send_item(it);
        end
      end
    end
    in_valid = 1'b0;

    // Drain: wait for every queued status, then let the clock run on so that a
    // stray extra output transaction would still be caught.
    while (sb.expected_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== buzzer_tone_melody_sequencer.f =====
+incdir+src
src/bts_pkg.sv
src/bts_core.sv
src/bts_skid.sv
src/buzzer_tone_melody_sequencer.sv
src/bts_checker.sv
test/testbench.sv
